// ----- rtl/cvmp_pkg.sv -----
// Shared types and constants for the character-driven motor pulser.
package cvmp_pkg;

    localparam int CHAR_COUNT = 128;
    localparam int CHAR_W     = 7;
    localparam int MOTOR_W    = 5;
    localparam int TICK_W     = 8;
    localparam int SLOT_W     = 2;
    localparam int MASK_W     = 30;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [TICK_W-1:0] PULSE_TICKS_RESET = 8'd20;

    // Word index of each configuration register
    localparam logic REG_PULSE_TICKS = 1'b0;

    typedef enum logic [1:0] {
        ACT_CHAR  = 2'd0,
        ACT_TICK  = 2'd1,
        ACT_WRITE = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHAR_RD,
        ST_CHAR_APPLY,
        ST_TICK,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic               valid;
        logic [MOTOR_W-1:0] motor;
    } map_entry_t;

    typedef struct packed {
        logic               load;
        logic               step;
        logic [MOTOR_W-1:0] motor;
        logic [TICK_W-1:0]  ticks;
    } bank_cmd_t;

endpackage

// ----- rtl/cvmp_in_if.sv -----
// Request channel carrying one motor pulser request.
interface cvmp_in_if;
    logic                         valid;
    logic                         ready;
    logic [1:0]                   action;
    logic [cvmp_pkg::CHAR_W-1:0]  char_code;
    logic [cvmp_pkg::SLOT_W-1:0]  slot;
    logic                         entry_valid;
    logic [cvmp_pkg::MOTOR_W-1:0] entry_motor;

    modport source (
        output valid, action, char_code, slot, entry_valid, entry_motor,
        input  ready
    );

    modport sink (
        input  valid, action, char_code, slot, entry_valid, entry_motor,
        output ready
    );
endinterface

// ----- rtl/cvmp_out_if.sv -----
// Result channel carrying the motor enable mask.
interface cvmp_out_if;
    logic                        valid;
    logic                        ready;
    logic [cvmp_pkg::MASK_W-1:0] motor_mask;

    modport source (
        output valid, motor_mask,
        input  ready
    );

    modport sink (
        input  valid, motor_mask,
        output ready
    );
endinterface

// ----- rtl/cvmp_motor_bank.sv -----
// Motor countdown counters and enable bits, one counter touched per cycle.
module cvmp_motor_bank #(
    parameter int NUM_MOTORS = 30
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cvmp_pkg::bank_cmd_t         cmd,
    output logic [cvmp_pkg::MASK_W-1:0] mask
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    logic [cvmp_pkg::TICK_W-1:0] count_reg [NUM_MOTORS];
    logic [NUM_MOTORS-1:0]       enable_reg;
    logic [IDX_W-1:0]            idx;
    logic [cvmp_pkg::TICK_W-1:0] count_cur;
    logic                        count_nz;
    logic                        count_last;

    // Select the counter named by the command
    assign idx        = cmd.motor[IDX_W-1:0];
    assign count_cur  = count_reg[idx];
    assign count_nz   = (count_cur != '0);
    assign count_last = (count_cur == cvmp_pkg::TICK_W'(1));

    // Load or decrement the selected counter, switch its motor on or off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                count_reg[i] <= '0;
            end
            enable_reg <= '0;
        end
        else if (cmd.load)
        begin
            count_reg[idx]  <= cmd.ticks;
            enable_reg[idx] <= 1'b1;
        end
        else if (cmd.step && count_nz)
        begin
            count_reg[idx] <= count_cur - cvmp_pkg::TICK_W'(1);
            if (count_last)
            begin
                enable_reg[idx] <= 1'b0;
            end
        end
    end

    // Map enable bits onto the fixed-width mask; extra motors stay hidden
    for (genvar g = 0; g < cvmp_pkg::MASK_W; g++)
    begin : g_mask
        if (g < NUM_MOTORS)
        begin : g_on
            assign mask[g] = enable_reg[g];
        end
        else
        begin : g_off
            assign mask[g] = 1'b0;
        end
    end

endmodule

// ----- rtl/char_to_vibration_motor_pulser_core.sv -----
// Sequence: a char event alternates ST_CHAR_RD and ST_CHAR_APPLY for each slot, a tick steps every
// motor counter in ST_TICK, a map write passes ST_WRITE, an unused action goes straight to ST_DONE;
// ST_DONE waits while an untaken result still holds the output register, then loads it.
// Flow: one request at a time, the next accepted only after ST_DONE returns to idle; the walks are
// the slot walk over the map memory's single read port and the walk over the motor counters.
// Reset: all motors off, counters zero, pulse_ticks 20; a clearing pass over every
// map entry empties the map before the first request is accepted.
module char_to_vibration_motor_pulser_core #(
    parameter int NUM_MOTORS     = 30,
    parameter int SLOTS_PER_CHAR = 3
) (
    input  logic                          clk,
    input  logic                          rst_n,
    cvmp_in_if.sink                       in,
    cvmp_out_if.source                    out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cvmp_pkg::PADDR_W-1:0]  paddr,
    input  logic [cvmp_pkg::PDATA_W-1:0]  pwdata,
    output logic [cvmp_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int MAP_DEPTH = cvmp_pkg::CHAR_COUNT * SLOTS_PER_CHAR;
    localparam int AW        = $clog2(MAP_DEPTH);
    localparam int SW        = (SLOTS_PER_CHAR > 1) ? $clog2(SLOTS_PER_CHAR) : 1;

    cvmp_pkg::state_t            state_reg, state_next;
    cvmp_pkg::action_t           act_reg, act_next;
    logic [cvmp_pkg::CHAR_W-1:0] char_reg, char_next;
    logic [cvmp_pkg::SLOT_W-1:0] slot_reg, slot_next;
    cvmp_pkg::map_entry_t        entry_reg, entry_next;
    logic [cvmp_pkg::TICK_W-1:0] pulse_reg;
    logic [AW-1:0]               clr_reg, clr_next;
    logic [SW-1:0]               scnt_reg, scnt_next;
    logic [cvmp_pkg::MOTOR_W-1:0] mcnt_reg, mcnt_next;
    logic                        out_valid_reg, out_valid_next;
    logic [cvmp_pkg::MASK_W-1:0] out_mask_reg, out_mask_next;

    cvmp_pkg::map_entry_t        map_mem [MAP_DEPTH];
    cvmp_pkg::map_entry_t        map_rd_reg;
    logic                        map_we;
    logic [AW-1:0]               map_waddr;
    cvmp_pkg::map_entry_t        map_wdata;
    logic [AW-1:0]               map_raddr;
    logic [AW-1:0]               char_base;

    cvmp_pkg::bank_cmd_t         bank_cmd;
    logic [cvmp_pkg::MASK_W-1:0] bank_mask;
    logic                        accept;
    logic                        out_free;
    logic                        slot_ok;
    logic                        motor_ok;
    logic                        cfg_wr;

    // Configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == cvmp_pkg::REG_PULSE_TICKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pulse_reg <= cvmp_pkg::PULSE_TICKS_RESET;
        end
        else if (cfg_wr)
        begin
            pulse_reg <= pwdata[cvmp_pkg::TICK_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == cvmp_pkg::REG_PULSE_TICKS)
        begin
            prdata = cvmp_pkg::PDATA_W'(pulse_reg);
        end
    end

    // Handshake helpers
    assign in.ready  = (state_reg == cvmp_pkg::ST_IDLE);
    assign accept    = in.valid && in.ready;
    assign out_free  = !out_valid_reg || out.ready;
    assign out.valid      = out_valid_reg;
    assign out.motor_mask = out_mask_reg;

    // Map addressing and range checks
    assign char_base = AW'(AW'(char_reg) * AW'(SLOTS_PER_CHAR));
    assign slot_ok   = ({1'b0, slot_reg} < 3'(SLOTS_PER_CHAR));
    assign motor_ok  = ({1'b0, map_rd_reg.motor} < 6'(NUM_MOTORS));
    assign map_raddr = char_base + AW'(scnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cvmp_pkg::ST_CLEAR:
            begin
                if (clr_reg == AW'(MAP_DEPTH - 1))
                begin
                    state_next = cvmp_pkg::ST_IDLE;
                end
            end
            cvmp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (cvmp_pkg::action_t'(in.action))
                        cvmp_pkg::ACT_CHAR:  state_next = cvmp_pkg::ST_CHAR_RD;
                        cvmp_pkg::ACT_TICK:  state_next = cvmp_pkg::ST_TICK;
                        cvmp_pkg::ACT_WRITE: state_next = cvmp_pkg::ST_WRITE;
                        default:             state_next = cvmp_pkg::ST_DONE;
                    endcase
                end
            end
            cvmp_pkg::ST_CHAR_RD:
            begin
                state_next = cvmp_pkg::ST_CHAR_APPLY;
            end
            cvmp_pkg::ST_CHAR_APPLY:
            begin
                if (scnt_reg == SW'(SLOTS_PER_CHAR - 1))
                begin
                    state_next = cvmp_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cvmp_pkg::ST_CHAR_RD;
                end
            end
            cvmp_pkg::ST_TICK:
            begin
                if (mcnt_reg == cvmp_pkg::MOTOR_W'(NUM_MOTORS - 1))
                begin
                    state_next = cvmp_pkg::ST_DONE;
                end
            end
            cvmp_pkg::ST_WRITE:
            begin
                state_next = cvmp_pkg::ST_DONE;
            end
            cvmp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = cvmp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cvmp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath controls
    always_comb
    begin
        act_next       = act_reg;
        char_next      = char_reg;
        slot_next      = slot_reg;
        entry_next     = entry_reg;
        clr_next       = clr_reg;
        scnt_next      = scnt_reg;
        mcnt_next      = mcnt_reg;
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        map_we         = 1'b0;
        map_waddr      = char_base + AW'(slot_reg);
        map_wdata      = entry_reg;
        bank_cmd       = '0;
        bank_cmd.ticks = pulse_reg;

        // Drop a result once it is taken
        if (out_valid_reg && out.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            cvmp_pkg::ST_CLEAR:
            begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                clr_next  = clr_reg + AW'(1);
            end
            cvmp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    act_next         = cvmp_pkg::action_t'(in.action);
                    char_next        = in.char_code;
                    slot_next        = in.slot;
                    entry_next.valid = in.entry_valid;
                    entry_next.motor = in.entry_motor;
                    scnt_next        = '0;
                    mcnt_next        = '0;
                end
            end
            cvmp_pkg::ST_CHAR_APPLY:
            begin
                bank_cmd.load  = map_rd_reg.valid && motor_ok;
                bank_cmd.motor = map_rd_reg.motor;
                scnt_next      = scnt_reg + SW'(1);
            end
            cvmp_pkg::ST_TICK:
            begin
                bank_cmd.step  = 1'b1;
                bank_cmd.motor = mcnt_reg;
                mcnt_next      = mcnt_reg + cvmp_pkg::MOTOR_W'(1);
            end
            cvmp_pkg::ST_WRITE:
            begin
                map_we = (act_reg == cvmp_pkg::ACT_WRITE) && slot_ok;
            end
            cvmp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = bank_mask;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cvmp_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and counter registers
    always_ff @(posedge clk)
    begin
        act_reg      <= act_next;
        char_reg     <= char_next;
        slot_reg     <= slot_next;
        entry_reg    <= entry_next;
        scnt_reg     <= scnt_next;
        mcnt_reg     <= mcnt_next;
        out_mask_reg <= out_mask_next;
    end

    // Character map memory, registered read
    always_ff @(posedge clk)
    begin
        if (map_we)
        begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rd_reg <= map_mem[map_raddr];
    end

    cvmp_motor_bank #(
        .NUM_MOTORS (NUM_MOTORS)
    ) u_bank (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (bank_cmd),
        .mask  (bank_mask)
    );

endmodule
